/* rtl/ure_pkg.sv */
// ----------------------------------------------------------------------------
// ure_pkg: shared types and constants of the ultrasonic echo ranger
// register indexes, status codes, configuration and result records
// ----------------------------------------------------------------------------
package ure_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned ScaleW = 18;
  localparam int unsigned CfgW   = 18;
  localparam int unsigned CfgIdxW = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCALE   = 2'd3;

  // reset values of the registers
  localparam logic [15:0]       TIMEOUT_RST = 16'd30000;
  localparam logic [7:0]        TRIGGER_RST = 8'd10;
  localparam logic [7:0]        SETTLE_RST  = 8'd2;
  localparam logic [ScaleW-1:0] SCALE_RST   = 18'd112394;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RISE = 2'd1;
  localparam logic [1:0] ST_STUCK   = 2'd2;

  typedef struct packed {
    logic [15:0]       timeout;
    logic [7:0]        trigger;
    logic [7:0]        settle;
    logic [ScaleW-1:0] scale;
  } cfg_t;

  // one result before the distance is attached
  typedef struct packed {
    logic            trigger;
    logic            busy;
    logic            done;
    logic [1:0]      status;
    logic [CntW-1:0] pulse;
  } res_t;

endpackage

/* rtl/ure_if.sv */
// ----------------------------------------------------------------------------
// ure_if: item channels of the ultrasonic echo ranger
// valid/ready channels for tick items and result items
// ----------------------------------------------------------------------------
interface ure_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface ure_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_out;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [15:0] pulse_us;
  logic [15:0] distance;

  modport source (output valid, output trigger_out, output busy_res, output done_res,
                  output status, output pulse_us, output distance, input ready);
  modport sink   (input valid, input trigger_out, input busy_res, input done_res,
                  input status, input pulse_us, input distance, output ready);
endinterface

/* rtl/ultrasonic_echo_ranger.sv */
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: ultrasonic ranging sensor controller
// tick-driven trigger and echo timing with distance in 0.01 cm
// ----------------------------------------------------------------------------
// Each input item is one microsecond tick with a start request and the
// sampled echo level; each tick yields exactly one result item with the
// trigger level, busy, done, status, pulse width and distance. The block
// takes one item per clock cycle, sustained, whenever the result side keeps
// up. An item passes three register stages (input register, sequencer result
// register, output register after the distance multiplier), and its result is
// shown from the output register. The sequencer counter updates once per tick
// as the item leaves the input register, which is the only loop in the design.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i only while no item is in flight: the user ensures it, not the block.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger import ure_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  ure_in_if.sink             item_i,
  ure_out_if.source          res_o
);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= TIMEOUT_RST;
      cfg_q.trigger <= TRIGGER_RST;
      cfg_q.settle  <= SETTLE_RST;
      cfg_q.scale   <= SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT: cfg_q.timeout <= cfg_data_i[15:0];
        CFG_TRIGGER: cfg_q.trigger <= cfg_data_i[7:0];
        CFG_SETTLE:  cfg_q.settle  <= cfg_data_i[7:0];
        CFG_SCALE:   cfg_q.scale   <= cfg_data_i[ScaleW-1:0];
        default:     cfg_q.timeout <= cfg_q.timeout;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or its item moves on
  logic in_vld_q, mid_vld_q, out_vld_q;
  logic out_en, mid_en, in_en;

  assign out_en       = !out_vld_q || res_o.ready;
  assign mid_en       = !mid_vld_q || out_en;
  assign in_en        = !in_vld_q || mid_en;
  assign item_i.ready = in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_en)  in_vld_q  <= item_i.valid;
      if (mid_en) mid_vld_q <= in_vld_q;
      if (out_en) out_vld_q <= mid_vld_q;
    end
  end

  // input register
  logic start_q, echo_q;

  always_ff @(posedge clk_i) begin
    if (in_en) begin
      start_q <= item_i.start_req;
      echo_q  <= item_i.echo_level;
    end
  end

  // sequencer, advances once per tick item
  res_t res_d, res_q;
  logic adv;

  assign adv = in_vld_q && mid_en;

  ure_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .start_i (start_q),
    .echo_i  (echo_q),
    .cfg_i   (cfg_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (mid_en) res_q <= res_d;
  end

  // distance from the registered pulse width; zero pulse gives zero distance
  logic [15:0] dist_w;

  ure_dist u_dist (
    .pulse_i (res_q.pulse),
    .scale_i (cfg_q.scale),
    .dist_o  (dist_w)
  );

  // output register
  res_t        out_q;
  logic [15:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q  <= res_q;
      dist_q <= dist_w;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.trigger_out = out_q.trigger;
  assign res_o.busy_res    = out_q.busy;
  assign res_o.done_res    = out_q.done;
  assign res_o.status      = out_q.status;
  assign res_o.pulse_us    = out_q.pulse;
  assign res_o.distance    = dist_q;

  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !(out_q.done && out_q.status == ST_OK)) |-> (dist_q == '0))
    else $error("distance outside an ok result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_vld_q && !mid_en) |=> (mid_vld_q && $stable(res_q)))
    else $error("stalled sequencer result changed");

  a_no_adv_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!mid_en) |-> !adv) else $error("sequencer advanced into a full stage");

endmodule

/* rtl/ure_ctrl.sv */
// ----------------------------------------------------------------------------
// ure_ctrl: measurement sequencer
// settle, trigger, rise wait and fall wait with their tick counter
// ----------------------------------------------------------------------------
module ure_ctrl import ure_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic start_i,
  input  logic echo_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SETTLE = 3'd1;
  localparam logic [2:0] PH_TRIG   = 3'd2;
  localparam logic [2:0] PH_RISE   = 3'd3;
  localparam logic [2:0] PH_FALL   = 3'd4;

  logic [2:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      ph;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_inc;
  logic            expired;

  always_comb begin
    ph  = phase_q;
    cnt = cnt_q;
    // a start on an idle tick is already the first settle or trigger tick
    if ((phase_q == PH_IDLE || phase_q > PH_FALL) && start_i) begin
      cnt = '0;
      ph  = (cfg_i.settle != 8'd0) ? PH_SETTLE : PH_TRIG;
    end
    cnt_inc = cnt + 16'd1;
    expired = (cnt > cfg_i.timeout) || (cnt == 16'hFFFF);

    phase_d = ph;
    cnt_d   = cnt;
    res_o   = '0;
    unique case (ph)
      PH_SETTLE: begin
        res_o.busy = 1'b1;
        cnt_d      = cnt_inc;
        if (cnt_inc >= {8'd0, cfg_i.settle}) begin
          phase_d = PH_TRIG;
          cnt_d   = '0;
        end
      end
      PH_TRIG: begin
        res_o.busy    = 1'b1;
        res_o.trigger = 1'b1;
        cnt_d         = cnt_inc;
        if (cnt_inc >= {8'd0, cfg_i.trigger}) begin
          phase_d = PH_RISE;
          cnt_d   = '0;
        end
      end
      PH_RISE: begin
        res_o.busy = 1'b1;
        if (echo_i) begin
          phase_d = PH_FALL;
          cnt_d   = 16'd1;
        end else if (expired) begin
          res_o.done   = 1'b1;
          res_o.status = ST_NO_RISE;
          phase_d      = PH_IDLE;
          cnt_d        = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_FALL: begin
        res_o.busy = 1'b1;
        if (!echo_i) begin
          res_o.done   = 1'b1;
          res_o.status = ST_OK;
          res_o.pulse  = cnt;
          phase_d      = PH_IDLE;
          cnt_d        = '0;
        end else if (expired) begin
          res_o.done   = 1'b1;
          res_o.status = ST_STUCK;
          phase_d      = PH_IDLE;
          cnt_d        = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> res_o.busy) else $error("done without busy");

  a_trig_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.trigger |-> !res_o.done) else $error("trigger on a done tick");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res_o.done) |=> (phase_q == PH_IDLE && cnt_q == '0))
    else $error("sequencer not idle after done");

  a_pulse_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.pulse != '0) |-> (res_o.done && res_o.status == ST_OK))
    else $error("pulse width outside an ok result");

endmodule

/* rtl/ure_dist.sv */
// ----------------------------------------------------------------------------
// ure_dist: distance scaling
// pulse width times Q16 scale, rounded half up, saturated to 16 bits
// ----------------------------------------------------------------------------
module ure_dist import ure_pkg::*; (
  input  logic [CntW-1:0]   pulse_i,
  input  logic [ScaleW-1:0] scale_i,
  output logic [15:0]       dist_o
);

  logic [CntW+ScaleW-1:0] prod;
  logic [CntW+ScaleW:0]   rnd;
  logic [CntW+ScaleW-16:0] whole;

  always_comb begin
    prod  = (CntW+ScaleW)'(pulse_i) * (CntW+ScaleW)'(scale_i);
    rnd   = {1'b0, prod} + (CntW+ScaleW+1)'(32768);
    whole = rnd[CntW+ScaleW:16];
    dist_o = (|whole[CntW+ScaleW-16:16]) ? 16'hFFFF : whole[15:0];
  end

endmodule
